// ===== sv/crll_pkg.sv =====
// Shared types and fixed constants for the capture-recapture log likelihood block.
// No dependencies.
package crll_pkg;

   // fixed field widths
   localparam int OCC_W     = 8;
   localparam int DEATH_W   = 9;
   localparam int IND_W     = 16;
   localparam int SUM_W     = 25;
   localparam int TOTAL_W   = 42;

   // records at or past this occasion add no terms
   localparam int MAX_OCCASIONS = 256;

   // log unit: Q1.30 mantissa and ln(2) in Q0.32
   localparam int              MANT_W  = 31;
   localparam int              LN2_W   = 32;
   localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;

   // two log lanes run side by side
   localparam int LANES    = 2;
   localparam int SURV_LN  = 0;
   localparam int CAP_LN   = 1;

   // control that travels down the pipeline with each transaction
   typedef struct packed {
      logic             valid;
      logic             surv_en;
      logic             cap_en;
      logic             emit;
      logic             last_all;
      logic [IND_W-1:0] individual;
   } ctl_type;

endpackage

// ===== sv/capture_recapture_log_likelihood.sv =====
// Capture-recapture log likelihood accumulator; uses crll_pkg.
// Throughput: one record per cycle unless a result held at the output stalls the pipeline;
// the pipeline length is set by the squaring pipeline of the log unit, one squaring
// multiplier per fraction bit of log2.
// Reset (synchronous, active high) clears the pipeline valids, the sums and rsp_valid.
module capture_recapture_log_likelihood #(
   parameter int PROB_BITS     = 16,
   parameter int LOG_FRAC_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   // record channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [crll_pkg::OCC_W-1:0]     req_occasion,
   input  logic [crll_pkg::OCC_W-1:0]     req_birth_occasion,
   input  logic [crll_pkg::DEATH_W-1:0]   req_death_occasion,
   input  logic                           req_death_known,
   input  logic                           req_was_caught,
   input  logic                           req_was_surveyed,
   input  logic [PROB_BITS-1:0]           req_survival_prob,
   input  logic [PROB_BITS-1:0]           req_capture_prob,
   input  logic [crll_pkg::IND_W-1:0]     req_individual,
   input  logic                           req_end_of_individual,
   input  logic                           req_end_of_all,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [crll_pkg::IND_W-1:0]     rsp_which_individual,
   output logic signed [crll_pkg::SUM_W-1:0]   rsp_survival_sum,
   output logic signed [crll_pkg::SUM_W-1:0]   rsp_capture_sum,
   output logic signed [crll_pkg::TOTAL_W-1:0] rsp_running_total,
   output logic                           rsp_final_res
);

   localparam int ARG_W   = PROB_BITS + 1;
   localparam int FRAC_W  = LOG_FRAC_BITS + 4;
   localparam int N_W     = $clog2(PROB_BITS + 1);
   localparam int MAG_W   = N_W + FRAC_W;
   localparam int PROD_W  = MAG_W + crll_pkg::LN2_W;
   localparam int SHIFT   = FRAC_W + crll_pkg::LN2_W - LOG_FRAC_BITS;
   localparam int TERM_W  = PROD_W + 1 - SHIFT;
   localparam int SUM_X_W = ((TERM_W > crll_pkg::SUM_W) ? TERM_W : crll_pkg::SUM_W) + 1;
   localparam int TOT_X_W = crll_pkg::TOTAL_W + 2;
   localparam int MW      = crll_pkg::MANT_W;
   localparam int LN      = crll_pkg::LANES;

   localparam logic signed [SUM_X_W-1:0] SUM_FLOOR =
      {{(SUM_X_W - crll_pkg::SUM_W + 1){1'b1}}, {(crll_pkg::SUM_W - 1){1'b0}}};
   localparam logic signed [TOT_X_W-1:0] TOT_FLOOR =
      {{(TOT_X_W - crll_pkg::TOTAL_W + 1){1'b1}}, {(crll_pkg::TOTAL_W - 1){1'b0}}};

   // -------------------------------------------------------------------------
   // pipeline flow: only a second result arriving at a full output stalls
   // -------------------------------------------------------------------------
   crll_pkg::ctl_type ctl_term_ff;
   logic              rsp_valid_ff;
   logic              adv;

   assign adv       = !(ctl_term_ff.valid && ctl_term_ff.emit && rsp_valid_ff && !rsp_ready);
   assign req_ready = adv;

   // -------------------------------------------------------------------------
   // input register
   // -------------------------------------------------------------------------
   logic                          in_valid_ff;
   logic [crll_pkg::OCC_W-1:0]    occ_ff, birth_ff;
   logic [crll_pkg::DEATH_W-1:0]  death_ff;
   logic                          known_ff, caught_ff, surveyed_ff, last_ind_ff, last_all_ff;
   logic [PROB_BITS-1:0]          phi_ff, p_ff;
   logic [crll_pkg::IND_W-1:0]    ind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
      end
      if (adv) begin
         occ_ff      <= req_occasion;
         birth_ff    <= req_birth_occasion;
         death_ff    <= req_death_occasion;
         known_ff    <= req_death_known;
         caught_ff   <= req_was_caught;
         surveyed_ff <= req_was_surveyed;
         phi_ff      <= req_survival_prob;
         p_ff        <= req_capture_prob;
         ind_ff      <= req_individual;
         last_ind_ff <= req_end_of_individual;
         last_all_ff <= req_end_of_all;
      end
   end

   // -------------------------------------------------------------------------
   // term selection and log argument normalization
   // -------------------------------------------------------------------------
   logic [crll_pkg::DEATH_W-1:0] t_ext, b_ext, t_plus1;
   logic                         in_range, surv_live, surv_death, cap_live;
   logic [ARG_W-1:0]             full, arg [LN];
   crll_pkg::ctl_type            ctl_norm_in;
   logic [N_W-1:0]               n_in [LN];
   logic [MW-1:0]                m_in [LN];

   always_comb begin
      logic [ARG_W-1:0] x;
      t_ext   = {1'b0, occ_ff};
      b_ext   = {1'b0, birth_ff};
      t_plus1 = t_ext + crll_pkg::DEATH_W'(1);
      in_range   = (32'(occ_ff) < crll_pkg::MAX_OCCASIONS);
      surv_live  = in_range && (b_ext <= t_ext) && (t_plus1 < death_ff);
      surv_death = in_range && (t_plus1 == death_ff) && !known_ff;
      cap_live   = in_range && surveyed_ff && (b_ext < t_ext) && (t_ext < death_ff);
      full = ARG_W'(1) << PROB_BITS;

      arg[crll_pkg::SURV_LN] = surv_live ? {1'b0, phi_ff} : (full - {1'b0, phi_ff});
      arg[crll_pkg::CAP_LN]  = caught_ff ? {1'b0, p_ff}   : (full - {1'b0, p_ff});

      ctl_norm_in.valid      = in_valid_ff;
      ctl_norm_in.surv_en    = surv_live || surv_death;
      ctl_norm_in.cap_en     = cap_live;
      ctl_norm_in.emit       = last_ind_ff || last_all_ff;
      ctl_norm_in.last_all   = last_all_ff;
      ctl_norm_in.individual = ind_ff;

      // leading one and Q1.30 mantissa; zero is read as one
      for (int l = 0; l < LN; l++) begin
         x = (arg[l] == '0) ? ARG_W'(1) : arg[l];
         n_in[l] = '0;
         for (int i = 0; i < ARG_W; i++) begin
            if (x[i]) n_in[l] = N_W'(i);
         end
         m_in[l] = MW'(x) << (MW - 1 - int'(n_in[l]));
      end
   end

   // -------------------------------------------------------------------------
   // squaring pipeline: one fraction bit of log2 per stage
   // -------------------------------------------------------------------------
   crll_pkg::ctl_type  ctl_ff  [FRAC_W+1];
   logic [MW-1:0]      m_ff    [FRAC_W+1][LN];
   logic [FRAC_W-1:0]  frac_ff [FRAC_W+1][LN];
   logic [N_W-1:0]     n_ff    [FRAC_W+1][LN];
   logic [MW:0]        sq_top  [FRAC_W][LN];

   always_comb begin
      logic [2*MW-1:0] sq;
      for (int k = 0; k < FRAC_W; k++) begin
         for (int l = 0; l < LN; l++) begin
            sq = (2*MW)'(m_ff[k][l]) * (2*MW)'(m_ff[k][l]);
            sq_top[k][l] = sq[2*MW-1:MW-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= FRAC_W; k++) ctl_ff[k] <= '0;
      end else if (adv) begin
         ctl_ff[0] <= ctl_norm_in;
         for (int k = 0; k < FRAC_W; k++) ctl_ff[k+1] <= ctl_ff[k];
      end
      if (adv) begin
         for (int l = 0; l < LN; l++) begin
            m_ff[0][l]    <= m_in[l];
            n_ff[0][l]    <= n_in[l];
            frac_ff[0][l] <= '0;
            for (int k = 0; k < FRAC_W; k++) begin
               m_ff[k+1][l]    <= sq_top[k][l][MW] ? sq_top[k][l][MW:1] : sq_top[k][l][MW-1:0];
               frac_ff[k+1][l] <= {frac_ff[k][l][FRAC_W-2:0], sq_top[k][l][MW]};
               n_ff[k+1][l]    <= n_ff[k][l];
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // magnitude in log2, scale by ln2, round to the output fraction
   // -------------------------------------------------------------------------
   crll_pkg::ctl_type  ctl_mag_ff, ctl_prod_ff;
   logic [MAG_W-1:0]   mag_in [LN], mag_ff [LN];
   logic [PROD_W-1:0]  prod_ff [LN];
   logic [PROD_W:0]    rnd [LN];
   logic [TERM_W-1:0]  term_ff [LN];

   always_comb begin
      logic [N_W-1:0] ipart;
      for (int l = 0; l < LN; l++) begin
         ipart     = N_W'(PROB_BITS) - n_ff[FRAC_W][l];
         mag_in[l] = (MAG_W'(ipart) << FRAC_W) - MAG_W'(frac_ff[FRAC_W][l]);
         rnd[l]    = {1'b0, prod_ff[l]} + ((PROD_W+1)'(1) << (SHIFT - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_mag_ff  <= '0;
         ctl_prod_ff <= '0;
         ctl_term_ff <= '0;
      end else if (adv) begin
         ctl_mag_ff  <= ctl_ff[FRAC_W];
         ctl_prod_ff <= ctl_mag_ff;
         ctl_term_ff <= ctl_prod_ff;
      end
      if (adv) begin
         for (int l = 0; l < LN; l++) begin
            mag_ff[l]  <= mag_in[l];
            prod_ff[l] <= PROD_W'(mag_ff[l]) * PROD_W'(crll_pkg::LN2_Q32);
            term_ff[l] <= rnd[l][PROD_W:SHIFT];
         end
      end
   end

   // -------------------------------------------------------------------------
   // accumulate with saturation; report on the last record
   // -------------------------------------------------------------------------
   logic signed [crll_pkg::SUM_W-1:0]   survival_acc_ff, capture_acc_ff;
   logic signed [crll_pkg::TOTAL_W-1:0] total_acc_ff;
   logic [TERM_W-1:0]                   ts, tc;
   logic signed [SUM_X_W-1:0]           sx, cx;
   logic signed [crll_pkg::SUM_W-1:0]   sa_in, ca_in;
   logic signed [TOT_X_W-1:0]           tx;
   logic signed [crll_pkg::TOTAL_W-1:0] tot_in;
   logic                                fire, emit_fire;

   always_comb begin
      ts = ctl_term_ff.surv_en ? term_ff[crll_pkg::SURV_LN] : '0;
      tc = ctl_term_ff.cap_en  ? term_ff[crll_pkg::CAP_LN]  : '0;
      sx = {{(SUM_X_W - crll_pkg::SUM_W){survival_acc_ff[crll_pkg::SUM_W-1]}}, survival_acc_ff}
           - {{(SUM_X_W - TERM_W){1'b0}}, ts};
      cx = {{(SUM_X_W - crll_pkg::SUM_W){capture_acc_ff[crll_pkg::SUM_W-1]}}, capture_acc_ff}
           - {{(SUM_X_W - TERM_W){1'b0}}, tc};
      sa_in = (sx < SUM_FLOOR) ? SUM_FLOOR[crll_pkg::SUM_W-1:0] : sx[crll_pkg::SUM_W-1:0];
      ca_in = (cx < SUM_FLOOR) ? SUM_FLOOR[crll_pkg::SUM_W-1:0] : cx[crll_pkg::SUM_W-1:0];
      tx = {{(TOT_X_W - crll_pkg::TOTAL_W){total_acc_ff[crll_pkg::TOTAL_W-1]}}, total_acc_ff}
           + {{(TOT_X_W - crll_pkg::SUM_W){sa_in[crll_pkg::SUM_W-1]}}, sa_in}
           + {{(TOT_X_W - crll_pkg::SUM_W){ca_in[crll_pkg::SUM_W-1]}}, ca_in};
      tot_in = (tx < TOT_FLOOR) ? TOT_FLOOR[crll_pkg::TOTAL_W-1:0] : tx[crll_pkg::TOTAL_W-1:0];
   end

   assign fire      = adv && ctl_term_ff.valid;
   assign emit_fire = fire && ctl_term_ff.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         survival_acc_ff <= '0;
         capture_acc_ff  <= '0;
         total_acc_ff    <= '0;
      end else if (fire) begin
         if (ctl_term_ff.emit) begin
            survival_acc_ff <= '0;
            capture_acc_ff  <= '0;
            total_acc_ff    <= ctl_term_ff.last_all ? '0 : tot_in;
         end else begin
            survival_acc_ff <= sa_in;
            capture_acc_ff  <= ca_in;
         end
      end
   end

   // output register
   logic [crll_pkg::IND_W-1:0]          rsp_ind_ff;
   logic signed [crll_pkg::SUM_W-1:0]   rsp_surv_ff, rsp_cap_ff;
   logic signed [crll_pkg::TOTAL_W-1:0] rsp_tot_ff;
   logic                                rsp_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_fire) begin
         rsp_ind_ff   <= ctl_term_ff.individual;
         rsp_surv_ff  <= sa_in;
         rsp_cap_ff   <= ca_in;
         rsp_tot_ff   <= tot_in;
         rsp_final_ff <= ctl_term_ff.last_all;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_which_individual = rsp_ind_ff;
   assign rsp_survival_sum     = rsp_surv_ff;
   assign rsp_capture_sum      = rsp_cap_ff;
   assign rsp_running_total    = rsp_tot_ff;
   assign rsp_final_res        = rsp_final_ff;

`ifndef SYNTHESIS
   // a stall only happens with a held result and a second one waiting behind it
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && ctl_term_ff.valid && ctl_term_ff.emit))
      else $error("stall without a blocked result");

   // sums never move while the pipeline is held
   a_hold_sums: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(total_acc_ff) && $stable(survival_acc_ff) && $stable(capture_acc_ff)))
      else $error("sums changed during stall");

   // log terms are never positive, so neither are the sums
   a_sums_nonpos: assert property (@(posedge clock) disable iff (reset)
      (survival_acc_ff == '0 || survival_acc_ff[crll_pkg::SUM_W-1]) &&
      (capture_acc_ff == '0 || capture_acc_ff[crll_pkg::SUM_W-1]) &&
      (total_acc_ff == '0 || total_acc_ff[crll_pkg::TOTAL_W-1]))
      else $error("positive log likelihood sum");

   // the total restarts after the last record is reported
   a_total_clear: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && ctl_term_ff.last_all) |=> (total_acc_ff == '0 && rsp_valid && rsp_final_res))
      else $error("total not cleared after final result");

   // a new result comes only from a last record leaving the pipeline
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(emit_fire))
      else $error("result without a last record");
`endif

endmodule

// ===== sim/tb_capture_recapture_log_likelihood.sv =====
// Self-checking testbench for capture_recapture_log_likelihood: drives occasion records,
// predicts per-individual log sums and the running total, and checks every result.
// Depends on crll_pkg and the block's RTL only.
module tb_capture_recapture_log_likelihood;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int              PROB_W      = 16;
   localparam int              LOG_F       = 12;
   localparam int              LOG2_F      = LOG_F + 4;
   localparam longint unsigned LN2_SCALED  = 64'd2977044472;
   localparam int unsigned     FULL_SCALE  = 32'd1 << PROB_W;
   localparam longint          SUM_FLOOR   = -(64'sd1 <<< 24);
   localparam longint          TOTAL_FLOOR = -(64'sd1 <<< 41);
   localparam int              HOLD_CYCLES = 300;
   localparam int              DRAIN_CYCLES = 40;
   localparam int              LONG_LEN    = 380;

   // one occasion record as offered on the req channel
   typedef struct packed {
      logic [crll_pkg::OCC_W-1:0]   occasion;
      logic [crll_pkg::OCC_W-1:0]   birth;
      logic [crll_pkg::DEATH_W-1:0] death;
      logic                         death_known;
      logic                         was_caught;
      logic                         was_surveyed;
      logic [PROB_W-1:0]            survival_prob;
      logic [PROB_W-1:0]            capture_prob;
      logic [crll_pkg::IND_W-1:0]   individual;
      logic                         end_of_individual;
      logic                         end_of_all;
   } record_type;

   // one per-individual report as seen on the rsp channel
   typedef struct packed {
      logic [crll_pkg::IND_W-1:0]          individual;
      logic signed [crll_pkg::SUM_W-1:0]   survival_sum;
      logic signed [crll_pkg::SUM_W-1:0]   capture_sum;
      logic signed [crll_pkg::TOTAL_W-1:0] running_total;
      logic                                final_res;
   } report_type;

   // Tracks the likelihood sums and holds the reports still to come.
   class likelihood_scoreboard;
      longint        survival_acc;
      longint        capture_acc;
      longint        total_acc;
      report_type    expected_reports[$];
      int unsigned   failures;

      function new();
         survival_acc = 0;
         capture_acc  = 0;
         total_acc    = 0;
         failures     = 0;
      endfunction

      // natural log of x / 2^16 in Q.12, log(0) clamped to log(2^-16)
      function longint ln_q12(int unsigned x);
         int unsigned     n;
         longint unsigned m;
         longint unsigned frac;
         longint unsigned mag;
         longint unsigned prod;
         if (x == 0) x = 1;
         n = 0;
         while (n < 31 && (x >> (n + 1)) != 0) n++;
         m = 64'(x) << (30 - n);
         frac = 0;
         // repeated squaring yields one log2 fraction bit per step
         for (int i = 0; i < LOG2_F; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
               frac = frac | 64'd1;
               m = m >> 1;
            end
         end
         mag  = (64'(PROB_W - n) << LOG2_F) - frac;
         prod = mag * LN2_SCALED;
         prod = (prod + (64'd1 << (LOG2_F + 31 - LOG_F))) >> (LOG2_F + 32 - LOG_F);
         return -longint'(prod);
      endfunction

      function longint floor_at(longint v, longint lo);
         return (v < lo) ? lo : v;
      endfunction

      // accumulate one accepted record; queue a report on an individual's last record
      function void note_record(record_type r);
         int         t;
         int         b;
         int         d;
         report_type rep;
         t = r.occasion;
         b = r.birth;
         d = r.death;
         if (t < crll_pkg::MAX_OCCASIONS) begin
            if (b <= t && t < d - 1)
               survival_acc = floor_at(survival_acc + ln_q12(r.survival_prob), SUM_FLOOR);
            else if (t == d - 1 && !r.death_known)
               survival_acc = floor_at(survival_acc +
                                       ln_q12(FULL_SCALE - r.survival_prob), SUM_FLOOR);
            if (r.was_surveyed && b < t && t < d)
               capture_acc = floor_at(capture_acc +
                                      (r.was_caught ? ln_q12(r.capture_prob)
                                                    : ln_q12(FULL_SCALE - r.capture_prob)),
                                      SUM_FLOOR);
         end
         if (!(r.end_of_individual || r.end_of_all)) return;
         total_acc = floor_at(total_acc + survival_acc + capture_acc, TOTAL_FLOOR);
         rep.individual    = r.individual;
         rep.survival_sum  = survival_acc[crll_pkg::SUM_W-1:0];
         rep.capture_sum   = capture_acc[crll_pkg::SUM_W-1:0];
         rep.running_total = total_acc[crll_pkg::TOTAL_W-1:0];
         rep.final_res     = r.end_of_all;
         expected_reports.push_back(rep);
         survival_acc = 0;
         capture_acc  = 0;
         if (r.end_of_all) total_acc = 0;
      endfunction

      // compare one accepted report with the oldest one predicted
      function void check_result(report_type got);
         report_type want;
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected report, individual %0d", $time, got.individual);
            failures++;
            return;
         end
         want = expected_reports.pop_front();
         if (got.individual !== want.individual) begin
            $display("%0t: which_individual exp %0d got %0d", $time,
                     want.individual, got.individual);
            failures++;
         end
         if (got.survival_sum !== want.survival_sum) begin
            $display("%0t: survival_sum exp %0d got %0d", $time,
                     want.survival_sum, got.survival_sum);
            failures++;
         end
         if (got.capture_sum !== want.capture_sum) begin
            $display("%0t: capture_sum exp %0d got %0d", $time,
                     want.capture_sum, got.capture_sum);
            failures++;
         end
         if (got.running_total !== want.running_total) begin
            $display("%0t: running_total exp %0d got %0d", $time,
                     want.running_total, got.running_total);
            failures++;
         end
         if (got.final_res !== want.final_res) begin
            $display("%0t: final_res exp %0b got %0b", $time,
                     want.final_res, got.final_res);
            failures++;
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_ready;
   record_type                          req_rec   = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [crll_pkg::IND_W-1:0]          rsp_which_individual;
   logic signed [crll_pkg::SUM_W-1:0]   rsp_survival_sum;
   logic signed [crll_pkg::SUM_W-1:0]   rsp_capture_sum;
   logic signed [crll_pkg::TOTAL_W-1:0] rsp_running_total;
   logic                                rsp_final_res;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;
   logic        hold_request  = 1'b0;
   int unsigned records_sent  = 0;

   likelihood_scoreboard sb;

   capture_recapture_log_likelihood u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_occasion          (req_rec.occasion),
      .req_birth_occasion    (req_rec.birth),
      .req_death_occasion    (req_rec.death),
      .req_death_known       (req_rec.death_known),
      .req_was_caught        (req_rec.was_caught),
      .req_was_surveyed      (req_rec.was_surveyed),
      .req_survival_prob     (req_rec.survival_prob),
      .req_capture_prob      (req_rec.capture_prob),
      .req_individual        (req_rec.individual),
      .req_end_of_individual (req_rec.end_of_individual),
      .req_end_of_all        (req_rec.end_of_all),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_which_individual  (rsp_which_individual),
      .rsp_survival_sum      (rsp_survival_sum),
      .rsp_capture_sum       (rsp_capture_sum),
      .rsp_running_total     (rsp_running_total),
      .rsp_final_res         (rsp_final_res)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random ready at the falling edge, or a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_ready = ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // report transactions are checked at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result('{rsp_which_individual, rsp_survival_sum, rsp_capture_sum,
                           rsp_running_total, rsp_final_res});
   end

   // offer one record from a falling edge; returns at the falling edge after acceptance
   task automatic send_record(record_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_rec   = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_record(r);
      records_sent++;
      @(negedge clock);
   endtask

   function automatic record_type mk(int t, int b, int d, bit known, bit caught,
                                     bit surveyed, int phi, int p, int ind, bit eoi,
                                     bit eoa);
      record_type r;
      r.occasion          = crll_pkg::OCC_W'(t);
      r.birth             = crll_pkg::OCC_W'(b);
      r.death             = crll_pkg::DEATH_W'(d);
      r.death_known       = known;
      r.was_caught        = caught;
      r.was_surveyed      = surveyed;
      r.survival_prob     = PROB_W'(phi);
      r.capture_prob      = PROB_W'(p);
      r.individual        = crll_pkg::IND_W'(ind);
      r.end_of_individual = eoi;
      r.end_of_all        = eoa;
      return r;
   endfunction

   // probabilities lean on the edges of the log table
   function automatic logic [PROB_W-1:0] pick_prob();
      unique case ($urandom_range(0, 7))
         0:       return '0;
         1:       return PROB_W'(1);
         2:       return '1;
         3:       return PROB_W'(16'h8000);
         default: return PROB_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic record_type noise_record();
      return mk($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 511),
                $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                pick_prob(), pick_prob(), $urandom_range(0, 65535),
                $urandom_range(0, 3) == 0, $urandom_range(0, 19) == 0);
   endfunction

   // one individual's life history, occasions ascending from birth
   task automatic send_individual(int unsigned max_len);
      record_type  r;
      int unsigned len;
      r.individual = crll_pkg::IND_W'($urandom_range(0, 65535));
      r.birth      = crll_pkg::OCC_W'($urandom_range(0, 250));
      if ($urandom_range(0, 7) == 0)
         r.death = crll_pkg::DEATH_W'($urandom_range(0, 511));
      else
         r.death = crll_pkg::DEATH_W'(r.birth + $urandom_range(1, 9));
      r.death_known = $urandom_range(0, 1);
      r.occasion    = r.birth;
      len = $urandom_range(1, max_len);
      for (int k = 0; k < len; k++) begin
         r.was_caught        = $urandom_range(0, 1);
         r.was_surveyed      = ($urandom_range(0, 4) != 0);
         r.survival_prob     = pick_prob();
         r.capture_prob      = pick_prob();
         r.end_of_individual = (k == len - 1);
         r.end_of_all        = (k == len - 1) && ($urandom_range(0, 11) == 0);
         send_record(r);
         r.occasion = crll_pkg::OCC_W'(r.occasion + $urandom_range(1, 2));
      end
   endtask

   // mostly well-formed histories, some raw noise
   task automatic random_phase(int unsigned n_records);
      int unsigned target;
      target = records_sent + n_records;
      while (records_sent < target) begin
         if ($urandom_range(0, 99) < 15)
            send_record(noise_record());
         else
            send_individual(8);
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: table edges, term windows, flags
      send_record(mk(0, 0, 1, 0, 0, 1, 16'h0000, 16'h0000, 16'hFFFF, 1, 0));
      send_record(mk(0, 0, 2, 0, 1, 1, 16'h0000, 16'h0000, 1, 0, 0));
      send_record(mk(1, 0, 2, 0, 1, 1, 16'hFFFF, 16'h0000, 1, 1, 0));
      // known death suppresses the last survival term
      send_record(mk(4, 2, 5, 1, 0, 1, 16'h8000, 16'hFFFF, 2, 0, 0));
      send_record(mk(3, 2, 5, 1, 1, 1, 16'hFFFF, 16'hFFFF, 2, 0, 0));
      send_record(mk(2, 2, 5, 1, 0, 0, 16'h0001, 16'h8000, 2, 1, 0));
      // death at zero: nothing applies
      send_record(mk(0, 0, 0, 0, 1, 1, 16'h0000, 16'h0000, 3, 1, 0));
      // after death, before birth
      send_record(mk(9, 2, 5, 0, 1, 1, 16'h1000, 16'h1000, 4, 0, 0));
      send_record(mk(1, 5, 9, 0, 1, 1, 16'h1000, 16'h1000, 4, 1, 0));
      send_record(mk(255, 255, 511, 0, 1, 1, 16'h5555, 16'hAAAA, 16'h0000, 0, 0));
      send_record(mk(255, 0, 256, 0, 0, 1, 16'hAAAA, 16'h5555, 16'h0000, 1, 0));
      // end_of_all alone still closes the individual
      send_record(mk(255, 0, 256, 1, 1, 1, 16'h7FFF, 16'h7FFF, 5, 0, 1));
      send_record(mk(7, 3, 20, 0, 1, 1, 16'h1234, 16'h4321, 16'h8000, 1, 1));
      send_record(mk(10, 0, 12, 0, 0, 1, 16'hFFFE, 16'h0002, 16'h00FF, 0, 0));
      send_record(mk(11, 0, 12, 0, 0, 1, 16'h7FFF, 16'h0001, 16'h00FF, 1, 0));

      send_idle_pct = 29;
      rsp_idle_pct  = 86;
      random_phase(45);

      send_idle_pct = 86;
      rsp_idle_pct  = 29;
      random_phase(45);

      // no idling; a long receiver hold-off backs the block up
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_request  = 1'b1;
      repeat (60) send_individual(1);

      // one long history drives both sums into their floor
      for (int k = 0; k < LONG_LEN; k++)
         send_record(mk(1 + k % 255, 0, 511, 0, 1, 1, 16'h0000, 16'h0000, 16'h5A5A,
                        k == LONG_LEN - 1, 0));
      req_valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
